/* hdl/ptdma_pkg.sv */
// Shared types and constants for the priority TDMA slot allocator.
// No dependencies; imported by every other file of the block.
`default_nettype none
package ptdma_pkg;
    localparam int NODES_DEF  = 16;
    localparam int ID_W       = 4;
    localparam int CLS_W      = 2;
    localparam int CAP_W      = 8;
    localparam int BYTES_W    = 24;
    localparam int OFF_W      = 9;
    localparam int SLOT_W     = 8;
    localparam int BPS_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OFF_W-1:0]     FIRST_SLOT = 9'd4;
    localparam logic [SLOT_W-1:0]    NEED_MAX   = 8'd255;
    localparam logic [SLOT_W-1:0]    TOTAL_RST  = 8'd32;
    localparam logic [BPS_W-1:0]     BPS_RST    = 16'd64;

    localparam logic [CLS_W-1:0]     CLS_CRIT   = 2'd0;
    localparam logic [CLS_W-1:0]     CLS_HIGH   = 2'd1;
    localparam logic [CLS_W-1:0]     CLS_ROUT   = 2'd2;
    localparam logic [CLS_W-1:0]     CLS_NONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BPS    = 2'd1;

    typedef enum logic [1:0] {
        CMD_REG  = 2'd0,
        CMD_UPD  = 2'd1,
        CMD_COMP = 2'd2,
        CMD_QRY  = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        ST_IDLE, ST_QRD, ST_QOUT,
        ST_CINIT, ST_CRD, ST_CEV, ST_CDIV, ST_CSRV, ST_CADV,
        ST_FRD, ST_FEV, ST_FADV,
        ST_RRD, ST_REV, ST_RDIV, ST_RSRV, ST_RADV,
        ST_NADV, ST_NRD, ST_NEV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic             accept;     // request taken this cycle
        logic             q_load;     // load query result
        logic             c_load;     // load compute result
        logic             c_init;     // start of compute
        logic [CLS_W-1:0] cls;        // class tested by wants
        logic             idx_zero;
        logic             idx_next;
        logic             idx_start;
        logic             div_start;
        logic             serve;
        logic             scan_rec;
        logic             rr_idx;
        logic             rr_wrap;
    } t_dp_cmd;

    typedef struct packed {
        logic wants;
        logic idx_last;
        logic step_last;
        logic left_zero;
        logic left_after_zero;
        logic short_grant;
        logic div_done;
        logic found;
        logic out_free;
    } t_dp_sts;
endpackage
`default_nettype wire

/* hdl/ptdma_if.sv */
// Request, response and configuration channel interfaces.
// Depends on ptdma_pkg for field widths.
`default_nettype none
interface ptdma_req_if;
    import ptdma_pkg::*;
    logic               valid;
    logic               ready;
    t_cmd               cmd;
    logic [ID_W-1:0]    node_id;
    logic [CLS_W-1:0]   node_class;
    logic [CAP_W-1:0]   max_slots;
    logic [BYTES_W-1:0] buffer_bytes;
    modport source (output valid, cmd, node_id, node_class, max_slots, buffer_bytes,
                    input ready);
    modport sink   (input valid, cmd, node_id, node_class, max_slots, buffer_bytes,
                    output ready);
endinterface

interface ptdma_rsp_if;
    import ptdma_pkg::*;
    logic              valid;
    logic              ready;
    logic              status;
    logic              granted;
    logic [OFF_W-1:0]  offset_slots;
    logic [SLOT_W-1:0] slots_left;
    modport source (output valid, status, granted, offset_slots, slots_left, input ready);
    modport sink   (input valid, status, granted, offset_slots, slots_left, output ready);
endinterface

interface ptdma_cfg_if;
    import ptdma_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/ptdma_div.sv */
// Slot need unit: min(ceil(bytes / slot payload size), 255), one quotient bit a cycle.
// Depends on ptdma_pkg.
`default_nettype none
module ptdma_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ptdma_pkg::BYTES_W-1:0] i_dividend,
    input  logic [ptdma_pkg::BPS_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [ptdma_pkg::SLOT_W-1:0]  o_quot
);
    import ptdma_pkg::*;
    localparam int REM_W = BYTES_W + 1;

    logic [REM_W-1:0]  r_rem;
    logic [BPS_W-1:0]  r_dv;
    logic [SLOT_W-1:0] r_q;
    logic [2:0]        r_k;
    logic              r_busy;
    logic              r_chk;
    logic              r_done;
    logic [BPS_W-1:0]  dv_nz;
    logic [REM_W-1:0]  num;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  sat_lim;

    assign dv_nz   = (i_divisor == '0) ? BPS_W'(1) : i_divisor;
    // round up: (d + div - 1)
    assign num     = REM_W'(i_dividend) + REM_W'(dv_nz) - REM_W'(1);
    assign trial   = REM_W'(r_dv) << r_k;
    assign sat_lim = {1'b0, r_dv, 8'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_chk && r_rem >= sat_lim) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (r_busy && !r_chk && r_k == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= num;
            r_dv  <= dv_nz;
            r_q   <= '0;
            r_k   <= 3'd7;
            r_chk <= 1'b1;
        end else if (r_busy) begin
            if (r_chk) begin
                r_chk <= 1'b0;
                if (r_rem >= sat_lim) begin
                    r_q <= NEED_MAX;
                end
            end else begin
                if (r_rem >= trial) begin
                    r_rem    <= r_rem - trial;
                    r_q[r_k] <= 1'b1;
                end
                r_k <= r_k - 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

/* hdl/ptdma_dp.sv */
// Datapath: node tables, grant table, schedule counters, output register.
// Depends on ptdma_pkg and ptdma_div.
`default_nettype none
module ptdma_dp #(
    parameter int NODES = ptdma_pkg::NODES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ptdma_pkg::t_dp_cmd               i_ctl,
    output ptdma_pkg::t_dp_sts               o_sts,
    input  ptdma_pkg::t_cmd                  i_cmd,
    input  logic [ptdma_pkg::ID_W-1:0]       i_node_id,
    input  logic [ptdma_pkg::CLS_W-1:0]      i_node_class,
    input  logic [ptdma_pkg::CAP_W-1:0]      i_max_slots,
    input  logic [ptdma_pkg::BYTES_W-1:0]    i_buffer_bytes,
    input  logic                             i_cfg_we,
    input  logic [ptdma_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ptdma_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_status,
    output logic                             o_granted,
    output logic [ptdma_pkg::OFF_W-1:0]      o_offset_slots,
    output logic [ptdma_pkg::SLOT_W-1:0]     o_slots_left
);
    import ptdma_pkg::*;
    localparam int NW = $clog2(NODES);
    localparam int AT_W = CLS_W + CAP_W;
    typedef logic [NW-1:0] t_idx;

    logic [SLOT_W-1:0]  r_total;
    logic [BPS_W-1:0]   r_bps;
    logic [NODES-1:0]   r_valid;
    logic [NODES-1:0]   r_gvalid;
    logic [AT_W-1:0]    r_attr_mem [NODES];
    logic [BYTES_W-1:0] r_dem_mem  [NODES];
    logic [OFF_W-1:0]   r_goff_mem [NODES];
    logic [AT_W-1:0]    r_attr_rd;
    logic [BYTES_W-1:0] r_dem_rd;
    logic [OFF_W-1:0]   r_goff_rd;
    t_idx               r_idx;
    t_idx               r_step;
    t_idx               r_qidx;
    logic               r_qok;
    logic [SLOT_W-1:0]  r_left;
    logic [OFF_W-1:0]   r_next;
    t_idx               r_low;
    t_idx               r_ge;
    logic               r_found_low;
    logic               r_found_ge;
    t_idx               r_rr;
    t_idx               r_second;
    logic [1:0]         r_nserved;
    logic               r_ov;
    logic               r_status;
    logic               r_granted;
    logic [OFF_W-1:0]   r_off;
    logic [SLOT_W-1:0]  r_sl;

    logic               in_ok;
    t_idx               in_idx;
    logic               wants;
    logic [CAP_W-1:0]   cap;
    logic [SLOT_W-1:0]  need;
    logic [SLOT_W-1:0]  g;
    logic [SLOT_W-1:0]  g_cap;
    logic               div_done;
    t_idx               start;
    t_idx               idx_wrap;

    assign in_ok  = int'(i_node_id) < NODES;
    assign in_idx = t_idx'(i_node_id);
    assign cap    = r_attr_rd[CAP_W-1:0];
    assign wants  = r_valid[r_idx] && (r_attr_rd[AT_W-1:CAP_W] == i_ctl.cls)
                    && (r_dem_rd != '0);
    assign g_cap  = (cap < need) ? cap : need;
    assign g      = (r_left < g_cap) ? r_left : g_cap;
    assign start  = r_found_ge ? r_ge : r_low;
    assign idx_wrap = (r_idx == t_idx'(NODES - 1)) ? '0 : r_idx + 1'b1;

    ptdma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_start),
        .i_dividend (r_dem_rd),
        .i_divisor  (r_bps),
        .o_done     (div_done),
        .o_quot     (need)
    );

    // tables
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && i_cmd == CMD_REG && in_ok) begin
            r_attr_mem[in_idx] <= {i_node_class, i_max_slots};
        end
        if (i_ctl.accept && i_cmd == CMD_REG && in_ok) begin
            r_dem_mem[in_idx] <= '0;
        end else if (i_ctl.accept && i_cmd == CMD_UPD && in_ok && r_valid[in_idx]) begin
            r_dem_mem[in_idx] <= i_buffer_bytes;
        end
        if (i_ctl.serve && g != '0) begin
            r_goff_mem[r_idx] <= r_next;
        end
        r_attr_rd <= r_attr_mem[r_idx];
        r_dem_rd  <= r_dem_mem[r_idx];
        r_goff_rd <= r_goff_mem[r_qidx];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= TOTAL_RST;
            r_bps    <= BPS_RST;
            r_valid  <= '0;
            r_gvalid <= '0;
            r_rr     <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_TOTAL) begin
                r_total <= i_cfg_data[SLOT_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == CFG_BPS) begin
                r_bps <= i_cfg_data;
            end
            if (i_ctl.accept && i_cmd == CMD_REG && in_ok) begin
                r_valid[in_idx] <= 1'b1;
            end
            if (i_ctl.c_init) begin
                r_gvalid <= '0;
            end else if (i_ctl.serve && g != '0) begin
                r_gvalid[r_idx] <= 1'b1;
            end
            if (i_ctl.rr_idx) begin
                r_rr <= r_idx;
            end else if (i_ctl.rr_wrap) begin
                r_rr <= (r_nserved == 2'd2) ? r_second : start;
            end
            if ((i_ctl.accept && (i_cmd == CMD_REG || i_cmd == CMD_UPD))
                || i_ctl.q_load || i_ctl.c_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // schedule walk
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_qidx <= in_idx;
            r_qok  <= in_ok;
        end
        if (i_ctl.c_init) begin
            r_left      <= r_total;
            r_next      <= FIRST_SLOT;
            r_found_low <= 1'b0;
            r_found_ge  <= 1'b0;
        end else if (i_ctl.serve) begin
            r_left <= r_left - g;
            r_next <= r_next + OFF_W'(g);
        end
        if (i_ctl.c_init || i_ctl.idx_zero) begin
            r_idx  <= '0;
            r_step <= '0;
        end else if (i_ctl.idx_start) begin
            r_idx  <= start;
            r_step <= '0;
        end else if (i_ctl.idx_next) begin
            r_idx  <= idx_wrap;
            r_step <= r_step + 1'b1;
        end
        if (i_ctl.idx_start) begin
            r_nserved <= 2'd0;
        end else if (i_ctl.serve && r_nserved != 2'd2) begin
            r_nserved <= r_nserved + 2'd1;
        end
        if (i_ctl.serve && r_nserved == 2'd1) begin
            r_second <= r_idx;
        end
        if (i_ctl.scan_rec && wants) begin
            if (!r_found_low) begin
                r_low       <= r_idx;
                r_found_low <= 1'b1;
            end
            if (!r_found_ge && r_idx >= r_rr) begin
                r_ge       <= r_idx;
                r_found_ge <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_status  <= (i_cmd == CMD_UPD) && !(in_ok && r_valid[in_idx]);
            r_granted <= 1'b0;
            r_off     <= '0;
            r_sl      <= '0;
        end else if (i_ctl.q_load) begin
            r_status  <= 1'b0;
            r_granted <= r_qok && r_gvalid[r_qidx];
            r_off     <= (r_qok && r_gvalid[r_qidx]) ? r_goff_rd : '0;
            r_sl      <= '0;
        end else if (i_ctl.c_load) begin
            r_status  <= 1'b0;
            r_granted <= 1'b0;
            r_off     <= '0;
            r_sl      <= r_left;
        end
    end

    assign o_sts.wants           = wants;
    assign o_sts.idx_last        = r_idx == t_idx'(NODES - 1);
    assign o_sts.step_last       = r_step == t_idx'(NODES - 1);
    assign o_sts.left_zero       = r_left == '0;
    assign o_sts.left_after_zero = g == r_left;
    assign o_sts.short_grant     = g < need;
    assign o_sts.div_done        = div_done;
    assign o_sts.found           = r_found_low;
    assign o_sts.out_free        = !r_ov || i_out_ready;

    assign o_out_valid    = r_ov;
    assign o_status       = r_status;
    assign o_granted      = r_granted;
    assign o_offset_slots = r_off;
    assign o_slots_left   = r_sl;
endmodule
`default_nettype wire

/* hdl/ptdma_ctrl.sv */
// Controller: sequences commands and the three-phase schedule walk.
// Depends on ptdma_pkg.
`default_nettype none
module ptdma_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ptdma_pkg::t_cmd    i_cmd,
    output logic               o_in_ready,
    input  ptdma_pkg::t_dp_sts i_sts,
    output ptdma_pkg::t_dp_cmd o_ctl
);
    import ptdma_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_high;
    logic   n_high;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE) && i_sts.out_free;
    assign accept     = o_in_ready && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_high  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_high  <= n_high;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_high       = r_high;
        o_ctl        = '0;
        o_ctl.accept = accept;
        o_ctl.cls    = CLS_ROUT;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_QRY:  n_state = ST_QRD;
                        CMD_COMP: n_state = ST_CINIT;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_QRD:  n_state = ST_QOUT;
            ST_QOUT: begin
                if (i_sts.out_free) begin
                    o_ctl.q_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_CINIT: begin
                o_ctl.c_init = 1'b1;
                n_high       = 1'b0;
                n_state      = ST_CRD;
            end
            ST_CRD: n_state = ST_CEV;
            ST_CEV: begin
                o_ctl.cls = r_high ? CLS_HIGH : CLS_CRIT;
                if (i_sts.wants) begin
                    o_ctl.div_start = 1'b1;
                    n_state         = ST_CDIV;
                end else begin
                    n_state = ST_CADV;
                end
            end
            ST_CDIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_CSRV;
                end
            end
            ST_CSRV: begin
                o_ctl.serve = 1'b1;
                n_state     = ST_CADV;
            end
            ST_CADV: begin
                if (i_sts.left_zero) begin
                    n_state = ST_FIN;
                end else if (i_sts.idx_last) begin
                    o_ctl.idx_zero = 1'b1;
                    n_high         = 1'b1;
                    n_state        = r_high ? ST_FRD : ST_CRD;
                end else begin
                    o_ctl.idx_next = 1'b1;
                    n_state        = ST_CRD;
                end
            end
            ST_FRD: n_state = ST_FEV;
            ST_FEV: begin
                o_ctl.scan_rec = 1'b1;
                n_state        = ST_FADV;
            end
            ST_FADV: begin
                if (!i_sts.idx_last) begin
                    o_ctl.idx_next = 1'b1;
                    n_state        = ST_FRD;
                end else if (i_sts.found) begin
                    o_ctl.idx_start = 1'b1;
                    n_state         = ST_RRD;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_RRD: n_state = ST_REV;
            ST_REV: begin
                if (i_sts.wants) begin
                    o_ctl.div_start = 1'b1;
                    n_state         = ST_RDIV;
                end else begin
                    n_state = ST_RADV;
                end
            end
            ST_RDIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_RSRV;
                end
            end
            ST_RSRV: begin
                o_ctl.serve = 1'b1;
                if (!i_sts.left_after_zero) begin
                    n_state = ST_RADV;
                end else if (i_sts.short_grant) begin
                    // cut short: pointer stays on this node
                    o_ctl.rr_idx = 1'b1;
                    n_state      = ST_FIN;
                end else begin
                    n_state = ST_NADV;
                end
            end
            ST_RADV: begin
                if (i_sts.step_last) begin
                    o_ctl.rr_wrap = 1'b1;
                    n_state       = ST_FIN;
                end else begin
                    o_ctl.idx_next = 1'b1;
                    n_state        = ST_RRD;
                end
            end
            ST_NADV: begin
                o_ctl.idx_next = 1'b1;
                n_state        = ST_NRD;
            end
            ST_NRD: n_state = ST_NEV;
            ST_NEV: begin
                if (i_sts.wants) begin
                    o_ctl.rr_idx = 1'b1;
                    n_state      = ST_FIN;
                end else begin
                    n_state = ST_NADV;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_ctl.c_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* hdl/priority_tdma_slot_allocator_unit.sv */
// Priority TDMA slot allocator top level.
// Depends on ptdma_pkg, ptdma_if, ptdma_ctrl, ptdma_dp (and ptdma_div below it).
//
// Usage:
//   i_req carries one command request: register node, update demand, compute
//   schedule or query offset. o_rsp returns exactly one result per request.
//   i_cfg writes total_slots (index 0) and the slot payload size in bytes
//   (index 1); it is always ready. The user must see that it is written only
//   while the block is idle; the block itself does not enforce this.
//   Register and update: result is registered in the cycle after acceptance.
//   Query: one grant-table read, then the result loads once the output is free.
//   Compute: walks the node table up to four times (critical, high, routine
//   search, routine service) and runs the bit-serial need divider for each
//   node with demand; the search for the next routine node after a service
//   pass may wrap round.
//   One request is in work at a time.
// Reset: node, grant and pointer state clear; config returns to 32 and 64.
// A stalled o_rsp holds its result; a new request is taken only once the
// output register is free or being emptied in that cycle.
`default_nettype none
module priority_tdma_slot_allocator_unit #(
    parameter int NODES = ptdma_pkg::NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptdma_req_if.sink   i_req,
    ptdma_rsp_if.source o_rsp,
    ptdma_cfg_if.sink   i_cfg
);
    import ptdma_pkg::*;

    t_dp_cmd ctl;
    t_dp_sts sts;

    assign i_cfg.ready = 1'b1;

    ptdma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_cmd      (i_req.cmd),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    ptdma_dp #(.NODES(NODES)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_cmd          (i_req.cmd),
        .i_node_id      (i_req.node_id),
        .i_node_class   (i_req.node_class),
        .i_max_slots    (i_req.max_slots),
        .i_buffer_bytes (i_req.buffer_bytes),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_status       (o_rsp.status),
        .o_granted      (o_rsp.granted),
        .o_offset_slots (o_rsp.offset_slots),
        .o_slots_left   (o_rsp.slots_left)
    );
endmodule
`default_nettype wire

/* hdl/ptdma_chk.sv */
// Port-level checks for the slot allocator, bound to the top level.
// Depends on ptdma_pkg and priority_tdma_slot_allocator_unit.
`default_nettype none
module ptdma_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input ptdma_pkg::t_cmd              i_req_cmd,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic                         i_rsp_granted,
    input logic [ptdma_pkg::OFF_W-1:0]  i_rsp_offset
);
    import ptdma_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_rsp_valid)
        else $error("response valid right after reset");

    a_quick_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_cmd == CMD_REG || i_req_cmd == CMD_UPD)
        |=> i_rsp_valid)
        else $error("register/update result missing");

    a_comp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_cmd == CMD_COMP |=> !i_req_ready)
        else $error("request taken during compute");

    a_no_grant_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_granted |-> i_rsp_offset == '0)
        else $error("offset without grant");
endmodule

bind priority_tdma_slot_allocator_unit ptdma_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_cmd     (i_req.cmd),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_granted (o_rsp.granted),
    .i_rsp_offset  (o_rsp.offset_slots)
);
`default_nettype wire
